[src/assert_macros.svh]
// Assertion helper macros for the RGBW crossfade sequencer.
// Expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rpcs_pkg.sv]
// Shared types, codes and palette lookup for the RGBW crossfade sequencer.
// No dependencies.
package rpcs_pkg;

    localparam int TIME_WIDTH_DEF    = 32;
    localparam int CHANNEL_WIDTH_DEF = 16;
    localparam int STEP_W            = 8;
    localparam int HOLD_W            = 10;
    localparam int PHASE_W           = 3;
    localparam int MODE_W            = 3;
    localparam int EFFECT_W          = 3;
    localparam int BRIGHT_W          = 16;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;
    localparam int NUM_CHAN          = 4;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 16'd100;

    localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RGB     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RED     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GREEN   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BLUE    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ORANGE  = 3'd6;

    localparam logic [EFFECT_W-1:0] EFF_STEADY = 3'd0;
    localparam logic [EFFECT_W-1:0] EFF_SLOW   = 3'd1;
    localparam logic [EFFECT_W-1:0] EFF_MEDIUM = 3'd2;
    localparam logic [EFFECT_W-1:0] EFF_FAST   = 3'd3;
    localparam logic [EFFECT_W-1:0] EFF_STROBE = 3'd4;

    localparam logic [STEP_W-1:0] PERIOD_SLOW   = 8'd150;
    localparam logic [STEP_W-1:0] PERIOD_MEDIUM = 8'd100;
    localparam logic [STEP_W-1:0] PERIOD_FAST   = 8'd30;
    localparam logic [STEP_W-1:0] PERIOD_STROBE = 8'd1;
    localparam logic [HOLD_W-1:0] HOLD_STROBE   = 10'd1000;

    localparam logic [15:0] ORANGE_RED   = 16'd255;
    localparam logic [15:0] ORANGE_GREEN = 16'd100;

    localparam logic [APB_ADDR_W-1:0] REG_BRIGHTNESS = 3'd0;

    // Channel order: 0 red, 1 green, 2 blue, 3 white.
    typedef logic [NUM_CHAN-1:0][15:0] rgbw_t;

    function automatic logic [PHASE_W-1:0] mode_size(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] sz;
        case (mode)
            MODE_RAINBOW: sz = 3'd6;
            MODE_RGB:     sz = 3'd3;
            default:      sz = 3'd1;
        endcase
        return sz;
    endfunction

    function automatic rgbw_t palette(input logic [MODE_W-1:0] mode,
                                      input logic [PHASE_W-1:0] phase,
                                      input logic [15:0] bright);
        rgbw_t c;
        logic  r;
        logic  g;
        logic  b;
        r = 1'b0;
        g = 1'b0;
        b = 1'b0;
        c = '0;
        c[3] = bright;
        case (mode)
            MODE_RAINBOW:
            begin
                r = (phase == 3'd0) || (phase == 3'd1) || (phase == 3'd5);
                g = (phase == 3'd1) || (phase == 3'd2) || (phase == 3'd3);
                b = (phase == 3'd3) || (phase == 3'd4) || (phase == 3'd5);
            end
            MODE_RGB:
            begin
                r = (phase == 3'd0);
                g = (phase == 3'd1);
                b = (phase == 3'd2);
            end
            MODE_RED:   r = 1'b1;
            MODE_GREEN: g = 1'b1;
            MODE_BLUE:  b = 1'b1;
            MODE_ORANGE: ;
            default:    c[3] = '0;
        endcase
        if (mode == MODE_ORANGE)
        begin
            c[0] = ORANGE_RED;
            c[1] = ORANGE_GREEN;
            c[2] = '0;
        end
        else
        begin
            c[0] = r ? bright : 16'd0;
            c[1] = g ? bright : 16'd0;
            c[2] = b ? bright : 16'd0;
        end
        return c;
    endfunction

endpackage

[src/rgbw_palette_crossfade_sequencer.sv]
// RGBW palette crossfade sequencer: one task call per transfer, at most one duty set out.
// Each accepted call is registered and checked against the hold, then runs the four
//   bit-serial multiply/divide lanes (8 + CHANNEL_WIDTH + 8 steps); result is registered.
// in_stall stays high until a call is through; a call still in its hold gives no result.
// Reset: rst_n async, clears colors, step, phase, timing; brightness goes to 100.
// Depends on rpcs_pkg, rpcs_cfg, rpcs_lane, assert_macros.svh.
module rgbw_palette_crossfade_sequencer #(
    parameter int TIME_WIDTH    = rpcs_pkg::TIME_WIDTH_DEF,
    parameter int CHANNEL_WIDTH = rpcs_pkg::CHANNEL_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rpcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rpcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rpcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [TIME_WIDTH-1:0]              now_time,
    input  logic [rpcs_pkg::MODE_W-1:0]        color_mode,
    input  logic [rpcs_pkg::EFFECT_W-1:0]      effect,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [CHANNEL_WIDTH-1:0]           red_duty,
    output logic [CHANNEL_WIDTH-1:0]           green_duty,
    output logic [CHANNEL_WIDTH-1:0]           blue_duty,
    output logic [CHANNEL_WIDTH-1:0]           white_duty
);
    import rpcs_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]               state_reg,  state_next;
    logic [TIME_WIDTH-1:0]    now_reg,    now_next;
    logic [MODE_W-1:0]        mode_reg,   mode_next;
    logic [EFFECT_W-1:0]      eff_reg,    eff_next;
    logic [TIME_WIDTH-1:0]    last_reg,   last_next;
    logic [STEP_W-1:0]        step_reg,   step_next;
    logic [STEP_W-1:0]        period_reg, period_next;
    logic [HOLD_W-1:0]        hold_reg,   hold_next;
    logic [PHASE_W-1:0]       phase_reg,  phase_next;
    logic [CHANNEL_WIDTH-1:0] cur_reg     [NUM_CHAN];
    logic [CHANNEL_WIDTH-1:0] cur_next    [NUM_CHAN];
    logic [CHANNEL_WIDTH-1:0] nxt_reg     [NUM_CHAN];
    logic [CHANNEL_WIDTH-1:0] nxt_next    [NUM_CHAN];
    logic [CHANNEL_WIDTH-1:0] res_reg     [NUM_CHAN];
    logic [CHANNEL_WIDTH-1:0] res_next    [NUM_CHAN];
    logic                     ovalid_reg, ovalid_next;

    logic [BRIGHT_W-1:0]      brightness;
    logic [NUM_CHAN-1:0]      lane_done;
    logic [CHANNEL_WIDTH-1:0] lane_duty   [NUM_CHAN];
    logic                     lane_start;
    logic [TIME_WIDTH-1:0]    elapsed;
    logic [STEP_W-1:0]        step_inc;
    logic [STEP_W-1:0]        per_new;
    logic [HOLD_W-1:0]        hold_new;
    logic [PHASE_W-1:0]       phase_fix;
    rgbw_t                    pal;

    rpcs_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .brightness (brightness)
    );

    for (genvar i = 0; i < NUM_CHAN; i++)
    begin : g_lane
        rpcs_lane #(
            .CHANNEL_WIDTH (CHANNEL_WIDTH)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (lane_start),
            .cur    (cur_reg[i]),
            .nxt    (nxt_reg[i]),
            .step   (step_reg),
            .period (period_reg),
            .done   (lane_done[i]),
            .duty   (lane_duty[i])
        );
    end

    assign elapsed    = now_reg - last_reg;
    assign lane_start = (state_reg == ST_CHECK)
                     && !(elapsed < {{(TIME_WIDTH-HOLD_W){1'b0}}, hold_reg});
    assign step_inc   = step_reg + 1'b1;
    assign phase_fix  = (phase_reg >= mode_size(mode_reg)) ? '0 : phase_reg;
    assign pal        = palette(mode_reg, phase_fix,
                                16'(brightness[CHANNEL_WIDTH-1:0]));

    always_comb
    begin
        case (eff_reg)
            EFF_STEADY: begin per_new = '0;            hold_new = '0;          end
            EFF_SLOW:   begin per_new = PERIOD_SLOW;   hold_new = '0;          end
            EFF_MEDIUM: begin per_new = PERIOD_MEDIUM; hold_new = '0;          end
            EFF_FAST:   begin per_new = PERIOD_FAST;   hold_new = '0;          end
            EFF_STROBE: begin per_new = PERIOD_STROBE; hold_new = HOLD_STROBE; end
            default:    begin per_new = period_reg;    hold_new = hold_reg;    end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        now_next    = now_reg;
        mode_next   = mode_reg;
        eff_next    = eff_reg;
        last_next   = last_reg;
        step_next   = step_reg;
        period_next = period_reg;
        hold_next   = hold_reg;
        phase_next  = phase_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next   = now_time;
                    mode_next  = color_mode;
                    eff_next   = effect;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (lane_start)
                begin
                    last_next  = now_reg;
                    state_next = ST_RUN;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                if (&lane_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    for (int i = 0; i < NUM_CHAN; i++)
                        res_next[i] = (period_reg == '0) ? nxt_reg[i] : lane_duty[i];
                    period_next = per_new;
                    hold_next   = hold_new;
                    if (step_inc >= per_new)
                    begin
                        for (int i = 0; i < NUM_CHAN; i++)
                        begin
                            cur_next[i] = nxt_reg[i];
                            nxt_next[i] = pal[i][CHANNEL_WIDTH-1:0];
                        end
                        phase_next = phase_fix + 1'b1;
                        step_next  = '0;
                    end
                    else
                        step_next = step_inc;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= '0;
            step_reg   <= '0;
            period_reg <= '0;
            hold_reg   <= '0;
            phase_reg  <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                cur_reg[i] <= '0;
                nxt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            step_reg   <= step_next;
            period_reg <= period_next;
            hold_reg   <= hold_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
            cur_reg    <= cur_next;
            nxt_reg    <= nxt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        mode_reg <= mode_next;
        eff_reg  <= eff_next;
        res_reg  <= res_next;
    end

    assign in_stall   = state_reg != ST_IDLE;
    assign out_valid  = ovalid_reg;
    assign red_duty   = res_reg[0];
    assign green_duty = res_reg[1];
    assign blue_duty  = res_reg[2];
    assign white_duty = res_reg[3];

    `ASSERT_IMPLIES(a_step_below_period, period_reg != '0, step_reg < period_reg, "step >= period")
    `ASSERT_IMPLIES(a_phase_range, 1'b1, phase_reg != 3'd7, "phase index out of range")
    `ASSERT_NEXT(a_lanes_finish_in_run, |lane_done, state_reg == ST_FINISH, "lane done outside run")
    `ASSERT_IMPLIES(a_result_from_finish, $rose(ovalid_reg), $past(state_reg) == ST_FINISH, "stray result")

endmodule

[src/rpcs_lane.sv]
// One channel's bit-serial interpolation: shift-add multiply of |cur-nxt| by the
// step, then restoring divide by the period. Depends on rpcs_pkg.
module rpcs_lane #(
    parameter int CHANNEL_WIDTH = rpcs_pkg::CHANNEL_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [CHANNEL_WIDTH-1:0]        cur,
    input  logic [CHANNEL_WIDTH-1:0]        nxt,
    input  logic [rpcs_pkg::STEP_W-1:0]     step,
    input  logic [rpcs_pkg::STEP_W-1:0]     period,
    output logic                            done,
    output logic [CHANNEL_WIDTH-1:0]        duty
);
    import rpcs_pkg::*;

    localparam int PW    = CHANNEL_WIDTH + STEP_W;
    localparam int CNT_W = $clog2(STEP_W + PW);
    localparam logic [CNT_W-1:0] MUL_END = CNT_W'(STEP_W);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(STEP_W + PW - 1);

    logic                     busy_reg,  busy_next;
    logic                     done_reg,  done_next;
    logic [CNT_W-1:0]         cnt_reg,   cnt_next;
    logic [CHANNEL_WIDTH-1:0] cur_reg,   cur_next;
    logic [CHANNEL_WIDTH-1:0] mag_reg,   mag_next;
    logic                     sub_reg,   sub_next;
    logic [STEP_W-1:0]        mult_reg,  mult_next;
    logic [STEP_W-1:0]        per_reg,   per_next;
    logic [PW-1:0]            work_reg,  work_next;
    logic [STEP_W:0]          rem_reg,   rem_next;
    logic [STEP_W:0]          rem_sh;
    logic                     ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        mag_next  = mag_reg;
        sub_next  = sub_reg;
        mult_next = mult_reg;
        per_next  = per_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg[STEP_W-1:0], work_reg[PW-1]};
        ge        = rem_sh >= {1'b0, per_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            cur_next  = cur;
            sub_next  = cur > nxt;
            mag_next  = (cur > nxt) ? (cur - nxt) : (nxt - cur);
            mult_next = step;
            per_next  = period;
            work_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg < MUL_END)
            begin
                work_next = {work_reg[PW-2:0], 1'b0}
                          + (mult_reg[STEP_W-1] ? PW'(mag_reg) : PW'(0));
                mult_next = {mult_reg[STEP_W-2:0], 1'b0};
            end
            else
            begin
                rem_next  = ge ? (rem_sh - {1'b0, per_reg}) : rem_sh;
                work_next = {work_reg[PW-2:0], ge};
            end
            if (cnt_reg == CNT_END)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        mag_reg  <= mag_next;
        sub_reg  <= sub_next;
        mult_reg <= mult_next;
        per_reg  <= per_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign duty = sub_reg ? (cur_reg - work_reg[CHANNEL_WIDTH-1:0])
                          : (cur_reg + work_reg[CHANNEL_WIDTH-1:0]);

endmodule

[src/rpcs_cfg.sv]
// APB-style register file holding the brightness level.
// Depends on rpcs_pkg.
module rpcs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rpcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rpcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rpcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [rpcs_pkg::BRIGHT_W-1:0]      brightness
);
    import rpcs_pkg::*;

    logic [BRIGHT_W-1:0] bright_reg, bright_next;
    logic                hit;

    assign hit = paddr[APB_ADDR_W-1] == REG_BRIGHTNESS[APB_ADDR_W-1];

    always_comb
    begin
        bright_next = bright_reg;
        if (psel && penable && pwrite && hit)
            bright_next = pwdata[BRIGHT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bright_reg <= BRIGHT_RESET;
        else
            bright_reg <= bright_next;
    end

    assign pready     = 1'b1;
    assign prdata     = hit ? {{(APB_DATA_W-BRIGHT_W){1'b0}}, bright_reg} : '0;
    assign brightness = bright_reg;

endmodule

[bench/testbench.sv]
// Self-checking bench for rgbw_palette_crossfade_sequencer: drives task calls with
// random idling, predicts RGBW duty sets with its own crossfade model and compares.
// Depends on rpcs_pkg and the sequencer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASE_CALLS = 205;
    localparam int unsigned DRAIN_CYCLES = 48;
    localparam int unsigned HOLD_CYCLES = 400;

    localparam logic [APB_ADDR_W-1:0] REG_UNMAPPED = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
    localparam logic [EFFECT_W-1:0] EFF_KEEP = 3'd5;
    localparam logic [EFFECT_W-1:0] EFF_SPARE6 = 3'd6;
    localparam logic [EFFECT_W-1:0] EFF_SPARE7 = 3'd7;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_kind_t;

    typedef struct {
        logic [31:0]         now_ms;
        logic [MODE_W-1:0]   mode;
        logic [EFFECT_W-1:0] eff;
    } call_t;

    typedef struct {
        call_t     call;
        row_kind_t kind;
        rgbw_t     duty;
    } call_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic [31:0]            now_time;
    logic [MODE_W-1:0]      color_mode;
    logic [EFFECT_W-1:0]    effect;
    logic                   out_valid;
    logic                   out_stall;
    logic [15:0]            red_duty;
    logic [15:0]            green_duty;
    logic [15:0]            blue_duty;
    logic [15:0]            white_duty;

    rgbw_t               duty_due [$];
    int unsigned         errors;
    int unsigned         cycle_count;
    bit                  noise_on;
    bit                  hold_req;
    int unsigned         stall_left;
    logic [31:0]         clock_ms;
    logic [MODE_W-1:0]   mode_now;
    string               chan_name [4] = '{"red_duty", "green_duty", "blue_duty", "white_duty"};

    // crossfade state
    logic [15:0]         bright_q;
    rgbw_t               fade_cur;
    rgbw_t               fade_nxt;
    logic [STEP_W-1:0]   step_q;
    logic [PHASE_W-1:0]  phase_q;
    logic [STEP_W-1:0]   period_q;
    logic [HOLD_W-1:0]   hold_q;
    logic [31:0]         last_ms;

    rgbw_palette_crossfade_sequencer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_time   (now_time),
        .color_mode (color_mode),
        .effect     (effect),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_duty   (red_duty),
        .green_duty (green_duty),
        .blue_duty  (blue_duty),
        .white_duty (white_duty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rgbw_t duty_set(input int r, input int g, input int b, input int w);
        rgbw_t c;
        c[0] = r[15:0];
        c[1] = g[15:0];
        c[2] = b[15:0];
        c[3] = w[15:0];
        return c;
    endfunction

    function automatic call_row_t row(input logic [31:0] t, input logic [MODE_W-1:0] m,
                                      input logic [EFFECT_W-1:0] e, input row_kind_t k,
                                      input rgbw_t d);
        call_row_t rw;
        rw.call.now_ms = t;
        rw.call.mode = m;
        rw.call.eff = e;
        rw.kind = k;
        rw.duty = d;
        return rw;
    endfunction

    function automatic logic [PHASE_W-1:0] palette_len(input logic [MODE_W-1:0] mode);
        if (mode == MODE_RAINBOW)
            return 3'd6;
        if (mode == MODE_RGB)
            return 3'd3;
        return 3'd1;
    endfunction

    function automatic rgbw_t palette_color(input logic [MODE_W-1:0] mode,
                                            input logic [PHASE_W-1:0] phase);
        rgbw_t c;
        logic  r;
        logic  g;
        logic  b;
        r = 1'b0;
        g = 1'b0;
        b = 1'b0;
        c = '0;
        case (mode)
            MODE_RAINBOW:
            begin
                r = (phase == 3'd0) || (phase == 3'd1) || (phase == 3'd5);
                g = (phase == 3'd1) || (phase == 3'd2) || (phase == 3'd3);
                b = (phase == 3'd3) || (phase == 3'd4) || (phase == 3'd5);
            end
            MODE_RGB:
            begin
                r = (phase == 3'd0);
                g = (phase == 3'd1);
                b = (phase == 3'd2);
            end
            MODE_RED:
                r = 1'b1;
            MODE_GREEN:
                g = 1'b1;
            MODE_BLUE:
                b = 1'b1;
            default:
                ;
        endcase
        if (mode == MODE_ORANGE)
        begin
            c[0] = ORANGE_RED;
            c[1] = ORANGE_GREEN;
            c[3] = bright_q;
        end
        else if (mode != MODE_OFF && mode != MODE_SPARE)
        begin
            c[0] = r ? bright_q : 16'd0;
            c[1] = g ? bright_q : 16'd0;
            c[2] = b ? bright_q : 16'd0;
            c[3] = bright_q;
        end
        return c;
    endfunction

    task automatic crossfade_call(input call_t c, output bit produced, output rgbw_t duty);
        logic [31:0] elapsed;
        int          cur_v;
        int          nxt_v;
        int          step_i;
        int          per_i;
        int          quo;
        elapsed = c.now_ms - last_ms;
        duty = '0;
        produced = (elapsed >= {22'd0, hold_q});
        if (produced)
        begin
            last_ms = c.now_ms;
            step_i = int'(step_q);
            per_i = int'(period_q);
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                if (per_i == 0)
                    duty[ch] = fade_nxt[ch];
                else
                begin
                    cur_v = int'(fade_cur[ch]);
                    nxt_v = int'(fade_nxt[ch]);
                    quo = ((cur_v - nxt_v) * step_i) / (-per_i);
                    cur_v = cur_v + quo;
                    duty[ch] = cur_v[15:0];
                end
            end
            step_q = step_q + 8'd1;
            case (c.eff)
                EFF_STEADY:
                begin
                    period_q = '0;
                    hold_q = '0;
                end
                EFF_SLOW:
                begin
                    period_q = PERIOD_SLOW;
                    hold_q = '0;
                end
                EFF_MEDIUM:
                begin
                    period_q = PERIOD_MEDIUM;
                    hold_q = '0;
                end
                EFF_FAST:
                begin
                    period_q = PERIOD_FAST;
                    hold_q = '0;
                end
                EFF_STROBE:
                begin
                    period_q = PERIOD_STROBE;
                    hold_q = HOLD_STROBE;
                end
                default:
                    ;
            endcase
            if (step_q >= period_q)
            begin
                fade_cur = fade_nxt;
                if (phase_q >= palette_len(c.mode))
                    phase_q = '0;
                fade_nxt = palette_color(c.mode, phase_q);
                phase_q = phase_q + 3'd1;
                step_q = '0;
            end
        end
    endtask

    task automatic check_result(input rgbw_t got);
        rgbw_t want;
        if (duty_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result expected none actual r=%0d g=%0d b=%0d w=%0d",
                     $time, got[0], got[1], got[2], got[3]);
        end
        else
        begin
            want = duty_due.pop_front();
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                if (want[ch] !== got[ch])
                begin
                    errors++;
                    $display("%0t: %s expected %0d actual %0d",
                             $time, chan_name[ch], want[ch], got[ch]);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result({white_duty, blue_duty, green_duty, red_duty});
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (noise_on && $urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b1;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == REG_BRIGHTNESS)
            bright_q = data[15:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_call(input call_t c, input row_kind_t kind, input rgbw_t typed,
                             output bit produced);
        rgbw_t duty;
        now_time = c.now_ms;
        color_mode = c.mode;
        effect = c.eff;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        crossfade_call(c, produced, duty);
        if (kind == ROW_TYPED)
            duty_due.push_back(typed);
        else if (kind == ROW_PREDICT && produced)
            duty_due.push_back(duty);
        @(negedge clk);
        if (noise_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (duty_due.size() != 0)
            @(negedge clk);
    endtask

    // mostly small time steps so fades run to completion, some jumps past the strobe hold
    task automatic next_random_call(output call_t c);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            clock_ms = $urandom();
        else if (pick < 15)
            clock_ms = clock_ms + $urandom_range(990, 1010);
        else
            clock_ms = clock_ms + $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0)
            mode_now = MODE_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        c.now_ms = clock_ms;
        c.mode = mode_now;
        if (pick < 85)
            c.eff = EFFECT_W'($urandom_range(5, 7));
        else if (pick < 97)
            c.eff = EFFECT_W'($urandom_range(0, 3));
        else
            c.eff = EFF_STROBE;
    endtask

    initial
    begin
        call_row_t         plan [$];
        call_t             c;
        bit                produced;
        int unsigned       done;
        logic [15:0]       levels [5];

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        now_time = '0;
        color_mode = MODE_OFF;
        effect = EFF_STEADY;
        errors = 0;
        cycle_count = 0;
        noise_on = 1'b1;
        hold_req = 1'b0;
        clock_ms = 32'h0000_1000;
        mode_now = MODE_RAINBOW;

        bright_q = BRIGHT_RESET;
        fade_cur = '0;
        fade_nxt = '0;
        step_q = '0;
        phase_q = '0;
        period_q = '0;
        hold_q = '0;
        last_ms = '0;

        levels[0] = 16'h0000;
        levels[1] = 16'hFFFF;
        levels[2] = 16'($urandom_range(2, 65534));
        levels[3] = 16'h0001;
        levels[4] = 16'($urandom_range(0, 65535));

        plan.push_back(row(32'd0, MODE_RED, EFF_STEADY, ROW_TYPED, duty_set(0, 0, 0, 0)));
        plan.push_back(row(32'd5, MODE_ORANGE, EFF_STEADY, ROW_TYPED,
                           duty_set(100, 0, 0, 100)));
        plan.push_back(row(32'd6, MODE_RAINBOW, EFF_SLOW, ROW_TYPED,
                           duty_set(255, 100, 0, 100)));
        plan.push_back(row(32'd7, MODE_RAINBOW, EFF_KEEP, ROW_PREDICT, '0));
        plan.push_back(row(32'd8, MODE_SPARE, EFF_SPARE7, ROW_PREDICT, '0));
        plan.push_back(row(32'd9, MODE_RGB, EFF_FAST, ROW_PREDICT, '0));
        plan.push_back(row(32'd10, MODE_RGB, EFF_MEDIUM, ROW_PREDICT, '0));
        plan.push_back(row(32'd11, MODE_GREEN, EFF_STROBE, ROW_PREDICT, '0));
        plan.push_back(row(32'd1010, MODE_GREEN, EFF_STROBE, ROW_SILENT, '0));
        plan.push_back(row(32'd1011, MODE_BLUE, EFF_STROBE, ROW_PREDICT, '0));
        plan.push_back(row(32'hFFFF_FFFF, MODE_BLUE, EFF_SPARE6, ROW_PREDICT, '0));
        plan.push_back(row(32'h0000_03E6, MODE_OFF, EFF_STEADY, ROW_SILENT, '0));
        for (int i = 0; i < 7; i++)
            plan.push_back(row(32'h0000_03E7, MODE_RAINBOW, EFF_STEADY, ROW_PREDICT, '0));
        plan.push_back(row(32'h0000_03E8, MODE_RGB, EFF_STEADY, ROW_PREDICT, '0));
        plan.push_back(row(32'h0000_03E9, MODE_RGB, EFF_STEADY, ROW_PREDICT, '0));
        plan.push_back(row(32'h0000_03EA, MODE_OFF, EFF_FAST, ROW_PREDICT, '0));
        plan.push_back(row(32'h0000_03EB, MODE_OFF, EFF_KEEP, ROW_PREDICT, '0));
        plan.push_back(row(32'h8000_0000, MODE_ORANGE, EFF_STEADY, ROW_PREDICT, '0));
        plan.push_back(row(32'h8000_0001, MODE_RED, EFF_KEEP, ROW_PREDICT, '0));

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_call(plan[i].call, plan[i].kind, plan[i].duty, produced);

        for (int p = 0; p < 5; p++)
        begin
            drain();
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (p == 2)
                apb_write(REG_UNMAPPED, $urandom());
            apb_write(REG_BRIGHTNESS, {16'($urandom()), levels[p]});
            noise_on = (p != 2) && (p != 4);
            done = 0;
            while (done < PHASE_CALLS)
            begin
                next_random_call(c);
                send_call(c, ROW_PREDICT, '0, produced);
                done++;
                if (p == 1 && done == 60)
                    hold_req = 1'b1;
                if (p == 3 && done == 80)
                    drain();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
